// File: rtl/debye_huckel_bdot_activity_top_assert.svh
// Assertion macros shared by the activity coefficient RTL.
// Relies on clk_i and rst_ni being visible at the point of use.
`ifndef DEBYE_HUCKEL_BDOT_ACTIVITY_TOP_ASSERT_SVH
`define DEBYE_HUCKEL_BDOT_ACTIVITY_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define DHB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dhb assertion failed");

// Check a consequence in the cycle after its cause.
`define DHB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dhb assertion failed");

`endif

// File: rtl/dhb_pkg.sv
// Package for the Debye-Huckel B-dot activity block: beat types, register
// indexes, output limits and the constant root table. No dependencies.
`default_nettype none

package dhb_pkg;

  typedef struct packed {
    logic signed [3:0] charge;
    logic [11:0]       ion_size;
  } in_t;

  typedef struct packed {
    logic [19:0]        activity_coeff;
    logic signed [23:0] log10_activity;
    logic               saturated;
  } out_t;

  typedef enum logic [1:0] {
    CfgIonic    = 2'd0,
    CfgCoefA    = 2'd1,
    CfgCoefB    = 2'd2,
    CfgCoefBdot = 2'd3
  } cfg_idx_e;

  localparam logic [19:0] GammaMax = 20'hFFFFF;
  // log2(10) with 30 fraction bits
  localparam logic [31:0] Log2Ten  = 32'd3566893132;

  // Integer square root, elaboration use only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] b;
    r   = '0;
    rem = v;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b != 0) begin
        if (rem >= r + b) begin
          rem = rem - (r + b);
          r   = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-i) with 30 fraction bits, each root taken from the previous one
  function automatic logic [30:0] pow_root(input int i);
    logic [63:0] r;
    r = isqrt64(64'd2 << 60);
    for (int k = 1; k < 30; k++) begin
      if (k < i) begin
        r = isqrt64(r << 30);
      end
    end
    return r[30:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/debye_huckel_bdot_activity_top.sv
// Top level of the Debye-Huckel B-dot activity coefficient pipeline.
// Depends on dhb_pkg and debye_huckel_bdot_activity_top_assert.svh.
//
//  channel | direction | handshake               | payload
//  in      | sink      | in_valid_i / in_ready_o | in_data_i (dhb_pkg::in_t)
//  out     | source    | out_valid_o/out_ready_i | out_data_o (dhb_pkg::out_t)
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat enters per cycle while no output stall, register write or update
// holds input off; the path runs through the one-bit-per-stage divider (QW quotient
// bits, 25 at FRAC_BITS = 16) and the thirty-stage power-of-two product chain.
// Every register write starts an update of sqrt(I) and the derived products,
// during which input is held off.
// Stages advance on their own: a bubble closes up and a stalled output holds.
// Reset clears all valid bits and loads the A, B and Bdot coefficients.
`default_nettype none

module debye_huckel_bdot_activity_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire dhb_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output dhb_pkg::out_t     out_data_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [19:0]  cfg_data_i
);

  `include "debye_huckel_bdot_activity_top_assert.svh"

  localparam int F    = FRAC_BITS;
  localparam int IW   = 20;
  localparam int SW   = (IW + F + 1) / 2;
  localparam int RADW = 2 * SW;
  localparam int CSW  = 16 + SW;
  localparam int ABW  = 12 + CSW;
  localparam int NUMW = CSW + 7;
  localparam int ADDW = ABW - F - 8;
  localparam int DENW = ((ADDW > F + 1) ? ADDW : F + 1) + 1;
  localparam int QW   = NUMW - F;
  localparam int WW   = NUMW + DENW;
  localparam int LINW = 16 + IW - F;
  localparam int LGM  = ((LINW > QW) ? LINW : QW) + 1;
  localparam int LGW  = (LGM > 25) ? LGM : 25;
  localparam int NW   = 57 - F - 30;
  localparam int SHW  = NW + 7;
  localparam int CW   = $clog2(SW + 1);
  localparam int NST  = QW + 35;
  localparam int ISL  = QW + 2;
  localparam int ISY  = QW + 3;
  localparam int IP   = QW + 4;
  localparam int ISO  = QW + 34;

  localparam longint RawA    = ((64'd5114 << F) + 64'd5000) / 64'd10000;
  localparam longint RawB    = ((64'd3288 << F) + 64'd5000) / 64'd10000;
  localparam longint RawBdot = ((64'd410 << F) + 64'd5000) / 64'd10000;
  localparam logic [15:0] RstA    = (RawA > 65535) ? 16'hFFFF : 16'(RawA);
  localparam logic [15:0] RstB    = (RawB > 65535) ? 16'hFFFF : 16'(RawB);
  localparam logic [15:0] RstBdot = (RawBdot > 65535) ? 16'hFFFF : 16'(RawBdot);
  localparam logic signed [LGW-1:0] LgHi = LGW'(64'sd8388607);
  localparam logic signed [LGW-1:0] LgLo = LGW'(-64'sd8388608);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_PROD
  } upd_state_e;

  // ---------------- configuration and derived constants ----------------
  upd_state_e          state_q, state_d;
  logic [IW-1:0]       ionic_q, ionic_d;
  logic [15:0]         coef_a_q, coef_b_q, coef_bdot_q;
  logic [RADW-1:0]     rad_q, rad_d;
  logic [SW+1:0]       rem_q, rem_d;
  logic [SW-1:0]       root_q, root_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CSW-1:0]      as_q, bs_q;
  logic [LINW-1:0]     lin_q;
  logic [SW+3:0]       r2;
  logic [SW+3:0]       trial;
  logic [2*IW+F-1:0]   rad_full;
  logic [IW+15:0]      lin_full;
  logic                cfg_wr;
  logic                busy;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign busy        = (state_q != ST_IDLE);
  assign ionic_d     = (cfg_wr && cfg_index_i == dhb_pkg::CfgIonic) ? cfg_data_i : ionic_q;
  assign rad_full    = {{IW{1'b0}}, ionic_d, {F{1'b0}}};
  assign r2          = {rem_q, rad_q[RADW-1 -: 2]};
  assign trial       = {2'b00, root_q, 2'b01};
  assign lin_full    = coef_bdot_q * ionic_q;

  // Sequence sqrt(I) one root bit per cycle, restarting on any register write, then form the products
  always_comb begin
    state_d = state_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    if (cfg_wr) begin
      state_d = ST_ROOT;
      rad_d   = rad_full[RADW-1:0];
      rem_d   = '0;
      root_d  = '0;
      cnt_d   = '0;
    end else begin
      case (state_q)
        ST_ROOT: begin
          rad_d = rad_q << 2;
          if (r2 >= trial) begin
            rem_d  = (SW+2)'(r2 - trial);
            root_d = {root_q[SW-2:0], 1'b1};
          end else begin
            rem_d  = r2[SW+1:0];
            root_d = {root_q[SW-2:0], 1'b0};
          end
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CW'(SW - 1)) begin
            state_d = ST_PROD;
          end
        end
        ST_PROD: begin
          state_d = ST_IDLE;
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ionic_q     <= '0;
      coef_a_q    <= RstA;
      coef_b_q    <= RstB;
      coef_bdot_q <= RstBdot;
      cnt_q       <= '0;
      as_q        <= '0;
      bs_q        <= '0;
      lin_q       <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ionic_q <= ionic_d;
      if (cfg_wr && cfg_index_i == dhb_pkg::CfgCoefA) begin
        coef_a_q <= cfg_data_i[15:0];
      end
      if (cfg_wr && cfg_index_i == dhb_pkg::CfgCoefB) begin
        coef_b_q <= cfg_data_i[15:0];
      end
      if (cfg_wr && cfg_index_i == dhb_pkg::CfgCoefBdot) begin
        coef_bdot_q <= cfg_data_i[15:0];
      end
      if (state_q == ST_PROD && !cfg_wr) begin
        as_q  <= coef_a_q * root_q;
        bs_q  <= coef_b_q * root_q;
        lin_q <= lin_full[IW+15:F];
      end
    end
  end

  // sqrt datapath registers
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  // ---------------- stage valid chain ----------------
  logic [NST-1:0] v_q;
  logic [NST-1:0] v_nx;
  logic [NST-1:0] adv;
  logic           in_acc;

  always_comb begin
    adv[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  // Hold input off while a register write or its update is under way
  assign in_ready_o = adv[0] && !busy && !cfg_valid_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign v_nx       = {v_q[NST-2:0], in_acc};

  // Advance each stage's valid bit when the stage moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_nx[k];
        end
      end
    end
  end

  // ---------------- front: z^2, a0*B*s, numerator, denominator ----------------
  logic [6:0]      s1_z2_q;
  logic [ABW-1:0]  s1_ab_q;
  logic            s1_neu_q;
  logic [NUMW-1:0] s2_num_q;
  logic [DENW-1:0] s2_den_q;
  logic            s2_neu_q;
  logic signed [7:0] z2_w;

  assign z2_w = in_data_i.charge * in_data_i.charge;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_z2_q  <= z2_w[6:0];
      s1_ab_q  <= in_data_i.ion_size * bs_q;
      s1_neu_q <= (in_data_i.charge == 4'sd0);
    end
    if (adv[1]) begin
      s2_num_q <= as_q * s1_z2_q;
      s2_den_q <= (DENW'(1) << F) + DENW'(s1_ab_q >> (F + 8));
      s2_neu_q <= s1_neu_q;
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  logic [NUMW-1:0] dv_rem_q [QW];
  logic [DENW-1:0] dv_den_q [QW];
  logic [QW-1:0]   dv_q_q   [QW];
  logic            dv_neu_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_div
    localparam int B = QW - 1 - i;
    logic [NUMW-1:0] rem_in;
    logic [DENW-1:0] den_in;
    logic [QW-1:0]   q_in;
    logic            neu_in;
    logic [WW-1:0]   dsh;
    logic            ge;
    logic [QW-1:0]   q_nx;

    if (i == 0) begin : g_first
      assign rem_in = s2_num_q;
      assign den_in = s2_den_q;
      assign q_in   = '0;
      assign neu_in = s2_neu_q;
    end else begin : g_next
      assign rem_in = dv_rem_q[i-1];
      assign den_in = dv_den_q[i-1];
      assign q_in   = dv_q_q[i-1];
      assign neu_in = dv_neu_q[i-1];
    end

    assign dsh = WW'(den_in) << B;
    assign ge  = (WW'(rem_in) >= dsh);

    always_comb begin
      q_nx    = q_in;
      q_nx[B] = ge;
    end

    // Subtract the shifted divisor where it fits
    always_ff @(posedge clk_i) begin
      if (adv[2+i]) begin
        dv_rem_q[i] <= ge ? (rem_in - dsh[NUMW-1:0]) : rem_in;
        dv_den_q[i] <= den_in;
        dv_q_q[i]   <= q_nx;
        dv_neu_q[i] <= neu_in;
      end
    end
  end

  // ---------------- log and exponent split ----------------
  logic signed [23:0]    sl_lg_q;
  logic signed [LGW-1:0] lg_w;
  logic signed [23:0]    lg_c;
  logic signed [56:0]    y_w;
  logic signed [NW-1:0]  sy_n_q;
  logic [29:0]           sy_f_q;
  logic signed [23:0]    sy_lg_q;

  assign lg_w = $signed(LGW'(lin_q)) - $signed(LGW'(dv_q_q[QW-1]));

  // Clamp the log; neutral species gives zero
  always_comb begin
    if (dv_neu_q[QW-1]) begin
      lg_c = '0;
    end else if (lg_w > LgHi) begin
      lg_c = LgHi[23:0];
    end else if (lg_w < LgLo) begin
      lg_c = LgLo[23:0];
    end else begin
      lg_c = lg_w[23:0];
    end
  end

  assign y_w = sl_lg_q * $signed({1'b0, dhb_pkg::Log2Ten});

  always_ff @(posedge clk_i) begin
    if (adv[ISL]) begin
      sl_lg_q <= lg_c;
    end
    if (adv[ISY]) begin
      sy_n_q  <= y_w[56:F+30];
      sy_f_q  <= y_w[F+29:F];
      sy_lg_q <= sl_lg_q;
    end
  end

  // ---------------- 2^f as a product of constant roots ----------------
  logic [30:0]          p_acc_q [30];
  logic [29:0]          p_f_q   [30];
  logic signed [NW-1:0] p_n_q   [30];
  logic signed [23:0]   p_lg_q  [30];

  for (genvar j = 0; j < 30; j++) begin : g_pow
    localparam logic [30:0] Root = dhb_pkg::pow_root(j + 1);
    logic [30:0]          acc_in;
    logic [29:0]          f_in;
    logic signed [NW-1:0] n_in;
    logic signed [23:0]   lg_in;
    logic [61:0]          prod;

    if (j == 0) begin : g_first
      assign acc_in = 31'd1 << 30;
      assign f_in   = sy_f_q;
      assign n_in   = sy_n_q;
      assign lg_in  = sy_lg_q;
    end else begin : g_next
      assign acc_in = p_acc_q[j-1];
      assign f_in   = p_f_q[j-1];
      assign n_in   = p_n_q[j-1];
      assign lg_in  = p_lg_q[j-1];
    end

    assign prod = acc_in * Root;

    // Fold in this root when its fraction bit is set
    always_ff @(posedge clk_i) begin
      if (adv[IP+j]) begin
        p_acc_q[j] <= f_in[29-j] ? prod[60:30] : acc_in;
        p_f_q[j]   <= f_in;
        p_n_q[j]   <= n_in;
        p_lg_q[j]  <= lg_in;
      end
    end
  end

  // ---------------- scale by 2^n and saturate ----------------
  logic signed [SHW-1:0] sh_w;
  logic [SHW-1:0]        amt_w;
  logic [30:0]           g_w;
  logic [19:0]           gamma_w;
  logic                  sat_w;
  dhb_pkg::out_t         out_q;

  assign sh_w  = $signed(SHW'(p_n_q[29])) + $signed(SHW'(F - 30));
  assign amt_w = SHW'(-sh_w);

  always_comb begin
    g_w     = '0;
    gamma_w = '0;
    sat_w   = 1'b0;
    if (!sh_w[SHW-1]) begin
      gamma_w = dhb_pkg::GammaMax;
      sat_w   = 1'b1;
    end else begin
      if (amt_w < SHW'(31)) begin
        g_w = p_acc_q[29] >> amt_w[4:0];
      end
      if (g_w > 31'(dhb_pkg::GammaMax)) begin
        gamma_w = dhb_pkg::GammaMax;
        sat_w   = 1'b1;
      end else begin
        gamma_w = g_w[19:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ISO]) begin
      out_q.activity_coeff <= gamma_w;
      out_q.log10_activity <= p_lg_q[29];
      out_q.saturated      <= sat_w;
    end
  end

  assign out_valid_o = v_q[ISO];
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  `DHB_ASSERT_NOW(a_busy_holds_input, busy, !in_ready_o)
  `DHB_ASSERT_NEXT(a_cfg_starts_update, cfg_wr, busy)
  `DHB_ASSERT_NOW(a_sat_is_clamped, out_valid_o && out_data_o.saturated, out_data_o.activity_coeff == dhb_pkg::GammaMax)

endmodule

`default_nettype wire

// File: bench/tb_debye_huckel_bdot_activity_top.sv
// Testbench for the Debye-Huckel B-dot activity coefficient pipeline.
// Depends on dhb_pkg and debye_huckel_bdot_activity_top; self-predicting, no files.
`default_nettype none

module tb_debye_huckel_bdot_activity_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB        = 16;
  localparam int IdleLimit = 20000;
  localparam int DrainWait = 120;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  dhb_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  dhb_pkg::out_t out_data_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i = '0;
  logic [19:0]   cfg_data_i = '0;

  debye_huckel_bdot_activity_top #(.FRAC_BITS(FB)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Shadow copy of the configuration registers
  logic [19:0] ionic_q;
  logic [15:0] coef_a_q, coef_b_q, coef_bdot_q;

  dhb_pkg::out_t gamma_pending[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;
  logic [63:0] exp2_roots[1:30];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, rem, b;
    r   = '0;
    rem = v;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 10^(lg / 2^FB), clamped to the gamma field
  function automatic logic [20:0] pow10_q(input longint lg);
    longint      y, y30, n, sh;
    logic [63:0] f, acc, g;
    y   = lg * 64'sd3566893132;
    y30 = y >>> FB;
    n   = y30 >>> 30;
    f   = y30 - (n <<< 30);
    acc = 64'd1 << 30;
    for (int i = 1; i <= 30; i++) begin
      if (f[30-i]) acc = (acc * exp2_roots[i]) >> 30;
    end
    sh = n + FB - 30;
    if (sh >= 0) return {1'b1, dhb_pkg::GammaMax};
    if (sh <= -63) return '0;
    g = acc >> (-sh);
    if (g > dhb_pkg::GammaMax) return {1'b1, dhb_pkg::GammaMax};
    return {1'b0, g[19:0]};
  endfunction

  function automatic dhb_pkg::out_t predict_activity(input dhb_pkg::in_t sp);
    dhb_pkg::out_t r;
    longint      z, lg;
    logic [63:0] s, num, den, t, lin;
    logic [20:0] pg;
    z = longint'(sp.charge);
    if (z == 0) begin
      r.activity_coeff = 20'd1 << FB;
      r.log10_activity = '0;
      r.saturated      = 1'b0;
      return r;
    end
    s   = int_sqrt(64'(ionic_q) << FB);
    num = 64'(coef_a_q) * 64'(z * z) * s;
    den = (64'd1 << FB) + ((64'(sp.ion_size) * 64'(coef_b_q) * s) >> (FB + 8));
    t   = num / den;
    lin = (64'(coef_bdot_q) * 64'(ionic_q)) >> FB;
    lg  = longint'(lin) - longint'(t);
    if (lg > 8388607) lg = 8388607;
    if (lg < -8388608) lg = -8388608;
    pg = pow10_q(lg);
    r.activity_coeff = pg[19:0];
    r.log10_activity = lg[23:0];
    r.saturated      = pg[20];
    return r;
  endfunction

  // Send one species beat; predict it at acceptance
  task automatic send_species(input logic [3:0] z, input logic [11:0] a0);
    dhb_pkg::in_t sp;
    sp.charge   = z;
    sp.ion_size = a0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= sp;
    do @(posedge clk_i); while (!in_ready_o);
    gamma_pending.push_back(predict_activity(sp));
  endtask

  // Drop valid and let every pending result drain
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (gamma_pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input dhb_pkg::cfg_idx_e idx, input logic [19:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      dhb_pkg::CfgIonic:    ionic_q     = d;
      dhb_pkg::CfgCoefA:    coef_a_q    = d[15:0];
      dhb_pkg::CfgCoefB:    coef_b_q    = d[15:0];
      dhb_pkg::CfgCoefBdot: coef_bdot_q = d[15:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [19:0] i, a, b, bd);
    write_reg(dhb_pkg::CfgIonic, i);
    write_reg(dhb_pkg::CfgCoefA, a);
    write_reg(dhb_pkg::CfgCoefB, b);
    write_reg(dhb_pkg::CfgCoefBdot, bd);
  endtask

  // Reset values: I = 0 gives log 0 for every charge
  task automatic test_reset_defaults();
    send_species(4'sd0, 12'd0);
    send_species(-4'sd8, 12'hFFF);
    send_species(4'sd7, 12'd0);
    send_species(4'sd1, 12'd768);
    wait_idle();
  endtask

  task automatic test_directed();
    // typical brine, every charge in range and out of range
    write_all(20'd6554, 20'd33515, 20'd21548, 20'd2687);
    for (int z = -8; z <= 7; z++) send_species(z[3:0], 12'd1024);
    send_species(4'sd2, 12'hFFF);
    wait_idle();
    // log clamps low, gamma rounds to zero
    write_all(20'hFFFFF, 20'hFFFF, 20'd0, 20'd0);
    send_species(-4'sd8, 12'd0);
    send_species(4'sd3, 12'hFFF);
    wait_idle();
    // Bdot term dominates: gamma saturates; neutral still gives one
    write_all(20'hFFFFF, 20'd0, 20'hFFFF, 20'hFFFF);
    send_species(4'sd1, 12'd0);
    send_species(4'sd0, 12'hFFF);
    wait_idle();
  endtask

  function automatic logic [19:0] rand_ionic();
    case ($urandom_range(3))
      0:       return 20'($urandom_range(0, 4095));
      1:       return 20'hFFFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] rand_coef();
    case ($urandom_range(5))
      0:       return 20'($urandom) & 20'hF0000;
      1:       return 20'hFFFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic test_random(input int idle, input int stall, input int count);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int k = 0; k < count; k++) begin
      if (k % 50 == 0) begin
        wait_idle();
        write_all(rand_ionic(), rand_coef(), rand_coef(), rand_coef());
      end
      if ($urandom_range(9) == 0) send_species(4'($urandom), 12'($urandom));
      else send_species(4'($urandom_range(0, 8) - 4), 12'($urandom));
    end
    wait_idle();
  endtask

  // Receiver: check each result beat, stall at random
  always @(posedge clk_i) begin
    dhb_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (gamma_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_data_o);
      end else begin
        want = gamma_pending.pop_front();
        if (out_data_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("gamma exp %h got %h, log exp %h got %h, sat exp %b got %b",
                     want.activity_coeff, out_data_o.activity_coeff,
                     want.log10_activity, out_data_o.log10_activity,
                     want.saturated, out_data_o.saturated);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("debye_huckel_bdot_activity_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    exp2_roots[1] = int_sqrt(64'd2 << 60);
    for (int i = 2; i <= 30; i++) exp2_roots[i] = int_sqrt(exp2_roots[i-1] << 30);
    ionic_q     = 20'd0;
    coef_a_q    = 16'd33515;
    coef_b_q    = 16'd21548;
    coef_bdot_q = 16'd2687;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random(0, 0, 150);
    test_random(79, 0, 150);
    test_random(0, 79, 150);
    test_random(34, 34, 150);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && gamma_pending.size() == 0) begin
      $display("debye_huckel_bdot_activity_top: match");
    end else begin
      $display("debye_huckel_bdot_activity_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
